### hdl/kpv_pkg.sv
// Package for the keypad PIN verifier with lockout.
// Holds field widths, key and result codes, register indexes and reset values.
// Used by the channel interfaces and by the top level.
package kpv_pkg;

	// Default depth of the entry buffer.
	localparam int MAX_DIGITS_DEF = 6;

	// Digits held in the stored PIN word.
	localparam int PIN_DIGITS = 6;

	// Field widths.
	localparam int KEY_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int BEEP_W    = 2;
	localparam int DIGITS_W  = 3;
	localparam int FAIL_W    = 4;
	localparam int PIN_W     = 24;
	localparam int LEN_CFG_W = 3;
	localparam int DEB_W     = 8;
	localparam int LOCK_W    = 12;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STORED_PIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STORED_LEN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES   = 3'd6;

	// Register reset values.
	localparam logic [PIN_W-1:0]     RST_STORED_PIN     = 24'd0;
	localparam logic [LEN_CFG_W-1:0] RST_STORED_LEN     = 3'd4;
	localparam logic [LEN_CFG_W-1:0] RST_MIN_LEN        = 3'd4;
	localparam logic [LEN_CFG_W-1:0] RST_MAX_LEN        = 3'd6;
	localparam logic [DEB_W-1:0]     RST_DEBOUNCE_TICKS = 8'd2;
	localparam logic [LOCK_W-1:0]    RST_LOCKOUT_TICKS  = 12'd3000;
	localparam logic [FAIL_W-1:0]    RST_MAX_FAILURES   = 4'd3;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [KEY_W-1:0] KEY_ENTER     = 4'd10;
	localparam logic [KEY_W-1:0] KEY_CANCEL    = 4'd11;
	localparam logic [KEY_W-1:0] KEY_NONE      = 4'd15;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_ENTRY     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 2'd2;

	// Beep codes.
	localparam logic [BEEP_W-1:0] BEEP_NONE    = 2'd0;
	localparam logic [BEEP_W-1:0] BEEP_CONFIRM = 2'd1;
	localparam logic [BEEP_W-1:0] BEEP_ERROR   = 2'd2;

	// Failure counter ceiling.
	localparam logic [FAIL_W-1:0] FAIL_SAT = 4'd15;

endpackage

### hdl/kpv_key_if.sv
// Input channel of the keypad PIN verifier: one sampled key word per tick.
// Depends on kpv_pkg for the key width.
interface kpv_key_if;
	import kpv_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);
endinterface

### hdl/kpv_result_if.sv
// Result channel of the keypad PIN verifier: one result word per tick.
// Depends on kpv_pkg for the field widths.
interface kpv_result_if;
	import kpv_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BEEP_W-1:0]   beep;
	logic [DIGITS_W-1:0] digits_entered;
	logic                locked;
	logic                display_refresh;
	logic [FAIL_W-1:0]   failure_count;

	modport source (output valid, output status, output beep, output digits_entered,
		output locked, output display_refresh, output failure_count, input ready);
	modport sink   (input valid, input status, input beep, input digits_entered,
		input locked, input display_refresh, input failure_count, output ready);
endinterface

### hdl/keypad_pin_verify_lockout.sv
// Keypad PIN verifier with lockout. Every key word is one tick of the keypad sampler and
// gives exactly one result word. A word passes through an input register, then one pass of
// logic updates the debounce, entry, failure and lockout state and loads the result register,
// so a new word is taken every clock cycle as long as results are taken. While a result waits
// at the output, the input register still takes one word and then holds it until the result
// is taken. Config registers take effect on the next word; the user must write them only
// while the block is idle, since the block itself does not enforce this.
// Depends on kpv_pkg, kpv_key_if and kpv_result_if.
module keypad_pin_verify_lockout #(
	parameter int MAX_DIGITS = kpv_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kpv_key_if.sink                         keys,
	kpv_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [kpv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [kpv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kpv_pkg::*;

	localparam int LEN_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CMP_N = (MAX_DIGITS < PIN_DIGITS) ? MAX_DIGITS : PIN_DIGITS;

	// Configuration registers.
	logic [PIN_W-1:0]     stored_pin_q;
	logic [LEN_CFG_W-1:0] stored_len_q;
	logic [LEN_CFG_W-1:0] min_len_q;
	logic [LEN_CFG_W-1:0] max_len_q;
	logic [DEB_W-1:0]     debounce_ticks_q;
	logic [LOCK_W-1:0]    lockout_ticks_q;
	logic [FAIL_W-1:0]    max_failures_q;

	// Input stage.
	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;

	// Verifier state.
	logic [KEY_W-1:0]  digit_buffer_q [MAX_DIGITS];
	logic [LEN_W-1:0]  entry_length_q;
	logic [FAIL_W-1:0] failures_q;
	logic [LOCK_W-1:0] lockout_q;
	logic [DEB_W-1:0]  stable_count_q;
	logic [KEY_W-1:0]  last_key_q;

	// Result register.
	logic                res_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BEEP_W-1:0]   beep_q;
	logic [DIGITS_W-1:0] digits_q;
	logic                locked_q;
	logic                refresh_q;
	logic [FAIL_W-1:0]   fail_count_q;

	// Handshake: the result register frees when empty or taken; the input register
	// takes a word whenever it is empty or moving on.
	logic advance;
	logic step;
	assign advance    = !res_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign keys.ready = !valid_s1 || advance;

	// Next-state logic for one tick.
	logic [STATUS_W-1:0] status_d;
	logic [BEEP_W-1:0]   beep_d;
	logic                refresh_d;
	logic [LEN_W-1:0]    length_d;
	logic [FAIL_W-1:0]   failures_d;
	logic [LOCK_W-1:0]   lockout_d;
	logic [DEB_W-1:0]    stable_d;
	logic [KEY_W-1:0]    last_key_d;
	logic                write_digit;
	logic [DEB_W-1:0]    need;
	logic [DEB_W-1:0]    stable_inc;
	logic [FAIL_W-1:0]   fail_inc;
	logic                pin_match;
	logic                len_ok;

	// The digits past the entry length are never read, so the buffer needs no clearing.
	always_comb begin
		pin_match = (entry_length_q == LEN_W'(stored_len_q))
			&& (entry_length_q <= LEN_W'(PIN_DIGITS));
		for (int i = 0; i < CMP_N; i++) begin
			if ((LEN_W'(i) < entry_length_q)
				&& (digit_buffer_q[i] != stored_pin_q[i*KEY_W +: KEY_W])) begin
				pin_match = 1'b0;
			end
		end
	end

	assign need       = (debounce_ticks_q == '0) ? DEB_W'(1) : debounce_ticks_q;
	assign stable_inc = stable_count_q + DEB_W'(1);
	assign fail_inc   = (failures_q < FAIL_SAT) ? failures_q + FAIL_W'(1) : FAIL_SAT;
	assign len_ok     = (entry_length_q >= LEN_W'(min_len_q))
		&& (entry_length_q <= LEN_W'(max_len_q));

	always_comb begin
		status_d    = STATUS_ENTRY;
		beep_d      = BEEP_NONE;
		refresh_d   = 1'b0;
		length_d    = entry_length_q;
		failures_d  = failures_q;
		lockout_d   = lockout_q;
		stable_d    = stable_count_q;
		last_key_d  = last_key_q;
		write_digit = 1'b0;
		if (lockout_q != '0) begin
			// Lockout tick: the key is ignored and the countdown runs.
			lockout_d = lockout_q - LOCK_W'(1);
			if (lockout_q == LOCK_W'(1)) begin
				failures_d = '0;
				refresh_d  = 1'b1;
			end
		end else if (key_s1 != last_key_q) begin
			stable_d   = '0;
			last_key_d = key_s1;
		end else if (stable_count_q < need) begin
			stable_d = stable_inc;
			if (stable_inc == need && key_s1 != KEY_NONE) begin
				if (key_s1 <= KEY_DIGIT_MAX) begin
					// Append a digit while the buffer has room.
					if (entry_length_q < LEN_W'(MAX_DIGITS)) begin
						write_digit = 1'b1;
						length_d    = entry_length_q + LEN_W'(1);
						beep_d      = BEEP_CONFIRM;
						refresh_d   = 1'b1;
					end
				end else if (key_s1 == KEY_ENTER) begin
					if (len_ok) begin
						refresh_d = 1'b1;
						length_d  = '0;
						if (pin_match) begin
							status_d   = STATUS_GRANTED;
							beep_d     = BEEP_CONFIRM;
							failures_d = '0;
							lockout_d  = '0;
						end else begin
							beep_d     = BEEP_ERROR;
							failures_d = fail_inc;
							if (fail_inc >= max_failures_q) begin
								if (lockout_ticks_q == '0) begin
									failures_d = '0;
								end else begin
									lockout_d = lockout_ticks_q;
								end
							end
						end
					end
				end else if (key_s1 == KEY_CANCEL) begin
					status_d   = STATUS_CANCELLED;
					beep_d     = BEEP_CONFIRM;
					refresh_d  = 1'b1;
					length_d   = '0;
					failures_d = '0;
					lockout_d  = '0;
				end
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_pin_q     <= RST_STORED_PIN;
			stored_len_q     <= RST_STORED_LEN;
			min_len_q        <= RST_MIN_LEN;
			max_len_q        <= RST_MAX_LEN;
			debounce_ticks_q <= RST_DEBOUNCE_TICKS;
			lockout_ticks_q  <= RST_LOCKOUT_TICKS;
			max_failures_q   <= RST_MAX_FAILURES;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STORED_PIN:     stored_pin_q     <= cfg_data[PIN_W-1:0];
				REG_STORED_LEN:     stored_len_q     <= cfg_data[LEN_CFG_W-1:0];
				REG_MIN_LEN:        min_len_q        <= cfg_data[LEN_CFG_W-1:0];
				REG_MAX_LEN:        max_len_q        <= cfg_data[LEN_CFG_W-1:0];
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[DEB_W-1:0];
				REG_LOCKOUT_TICKS:  lockout_ticks_q  <= cfg_data[LOCK_W-1:0];
				REG_MAX_FAILURES:   max_failures_q   <= cfg_data[FAIL_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid) begin
			key_s1 <= keys.key_code;
		end
	end

	// Verifier state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_length_q <= '0;
			failures_q     <= '0;
			lockout_q      <= '0;
			stable_count_q <= '0;
			last_key_q     <= KEY_NONE;
		end else if (step) begin
			entry_length_q <= length_d;
			failures_q     <= failures_d;
			lockout_q      <= lockout_d;
			stable_count_q <= stable_d;
			last_key_q     <= last_key_d;
		end
	end

	// Entry buffer, written at the current entry length.
	always_ff @(posedge clk) begin
		if (step && write_digit) begin
			digit_buffer_q[entry_length_q[IDX_W-1:0]] <= key_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q     <= status_d;
			beep_q       <= beep_d;
			digits_q     <= length_d[DIGITS_W-1:0];
			locked_q     <= (lockout_d != '0);
			refresh_q    <= refresh_d;
			fail_count_q <= failures_d;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.status          = status_q;
	assign result.beep            = beep_q;
	assign result.digits_entered  = digits_q;
	assign result.locked          = locked_q;
	assign result.display_refresh = refresh_q;
	assign result.failure_count   = fail_count_q;

`ifndef SYNTH
	// A word that leaves the input register shows up as a result in the next cycle.
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> result.valid)
		else $error("word left the input register without a result");

	// The entry buffer stays empty while the lockout countdown runs.
	a_lockout_empty_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(lockout_q != '0) |-> (entry_length_q == '0))
		else $error("digits held during lockout");

	// A grant restarts the session.
	a_grant_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STATUS_GRANTED) |->
		(result.digits_entered == '0 && result.failure_count == '0 && !result.locked))
		else $error("grant without session restart");
`endif

endmodule
